@@ sv/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lfpm_pkg.sv @@
package lfpm_pkg;

  // shared multiplier operand and result widths
  localparam int OPA_W  = 25;
  localparam int OPB_W  = 17;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 33;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [6:0]  W_OUTER = 7'sd20;
  localparam logic signed [6:0]  W_INNER = 7'sd12;

  localparam logic signed [11:0] SPEED_REVERSE  = -12'sd800;
  localparam logic signed [11:0] SPEED_TURN     = 12'sd900;
  localparam logic signed [11:0] SPEED_STRAIGHT = 12'sd1200;
  localparam logic signed [11:0] SPEED_STOP     = 12'sd0;

  // 1177/1024 back scale, applied as acc*1177 >> 18
  localparam logic signed [OPB_W-1:0] BACK_SCALE = 17'sd1177;
  // any |acc| beyond this saturates the back drive anyway
  localparam logic signed [ACC_W-1:0] BACK_CLAMP = 33'sd4194304;

  localparam logic [15:0] PROP_GAIN_RST  = 16'd5120;
  localparam logic [13:0] INTEG_LIM_RST  = 14'd10000;
  localparam logic [12:0] PWM_LIM_RST    = 13'd6000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_POLARITY   = 3'd3,
    REG_INTEG_LIM  = 3'd4,
    REG_PWM_LIM    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

endpackage

@@ sv/lfpm_if.sv @@
interface lfpm_in_if;
  logic valid;
  logic ready;
  logic outer_left_raw;
  logic inner_left_raw;
  logic inner_right_raw;
  logic outer_right_raw;
  logic run_enable;

  modport source (output valid, outer_left_raw, inner_left_raw, inner_right_raw,
                  outer_right_raw, run_enable, input ready);
  modport sink (input valid, outer_left_raw, inner_left_raw, inner_right_raw,
                outer_right_raw, run_enable, output ready);
endinterface

interface lfpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] drive_left;
  logic signed [13:0] drive_right;
  logic signed [13:0] drive_back;
  logic signed [6:0]  line_error;

  modport source (output valid, drive_left, drive_right, drive_back, line_error,
                  input ready);
  modport sink (input valid, drive_left, drive_right, drive_back, line_error,
                output ready);
endinterface

interface lfpm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/line_follow_pid_motor_mix_top.sv @@
// channel | dir | modport            | payload
// sens    | in  | lfpm_in_if.sink    | four raw sensor bits, run_enable
// drv     | out | lfpm_out_if.source | drive_left/right/back, line_error
// cfg     | in  | lfpm_cfg_if.sink   | index, data (always ready)
//
// From accept to the result register an item steps through ST_PROP, ST_INTEG,
// ST_DERIV, ST_SUM, ST_BACK and ST_MIX: one 25x17 multiplier is stepped through
// the P, I, D and back-scale products. sens.ready returns as the result loads.
// sens.ready is high only while the sequencer is idle; a waiting result
// does not block the next accept, but a second result holds the last step.
// rst is synchronous: config registers return to defaults, PID state clears.
`include "assert_macros.svh"

module line_follow_pid_motor_mix_top import lfpm_pkg::*; (
  input logic       clk,
  input logic       rst,
  lfpm_in_if.sink   sens,
  lfpm_out_if.source drv,
  lfpm_cfg_if.sink  cfg
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROP, ST_INTEG, ST_DERIV, ST_SUM, ST_BACK, ST_MIX
  } state_t;

  state_t state;

  logic [15:0] prop_gain, integ_gain, deriv_gain;
  logic        line_polarity;
  logic [13:0] integ_limit;
  logic [12:0] pwm_limit;

  logic signed [14:0] err_sum;
  logic signed [6:0]  last_err;
  logic signed [11:0] base_speed;

  logic signed [6:0]  err;
  logic signed [7:0]  diff;
  logic               run_q;
  logic               wz_q;

  logic               out_valid;
  logic signed [13:0] left_q, right_q, back_q;
  logic signed [6:0]  lerr_q;

  // ---------------- accept-cycle error, integral and base speed
  logic               al, bl, cl, dl;
  logic signed [6:0]  e_pos, e_new, e_mag;
  logic               wz, turn;
  logic signed [15:0] sum16, lim16;
  logic signed [14:0] sum_next;
  logic signed [7:0]  diff_next;
  logic signed [11:0] base_next;
  logic               accept;

  assign accept = sens.valid && sens.ready;

  // a sensor contributes iff its raw bit is 0; polarity sets the sign
  assign al = !sens.outer_left_raw;
  assign bl = !sens.inner_left_raw;
  assign cl = !sens.inner_right_raw;
  assign dl = !sens.outer_right_raw;

  always_comb begin
    e_pos = (al ? W_OUTER : 7'sd0) + (bl ? W_INNER : 7'sd0)
          - (cl ? W_INNER : 7'sd0) - (dl ? W_OUTER : 7'sd0);
    e_new = line_polarity ? e_pos : -e_pos;
    e_mag = e_new[6] ? -e_new : e_new;
    wz    = e_mag < 7'sd10;
    turn  = e_mag >= 7'sd30;

    sum16 = {err_sum[14], err_sum} + {{9{e_new[6]}}, e_new};
    lim16 = {2'b00, integ_limit};
    if (sum16 > lim16) begin
      sum_next = lim16[14:0];
    end else if (sum16 < -lim16) begin
      sum_next = 15'(-lim16);
    end else begin
      sum_next = sum16[14:0];
    end

    diff_next = {e_new[6], e_new} - {last_err[6], last_err};

    base_next = base_speed;
    if (line_polarity) begin
      if (al && bl && cl && dl) begin
        base_next = SPEED_REVERSE;
      end else if (turn) begin
        base_next = SPEED_TURN;
      end else begin
        base_next = SPEED_STRAIGHT;
      end
    end else begin
      if (!al && !bl && !cl && !dl) begin
        base_next = SPEED_REVERSE;
      end else if (!wz) begin
        base_next = SPEED_STOP;
      end
    end
  end

  // ---------------- shared multiplier
  mac_ctl_t                  mac_ctl;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_cl;

  lfpm_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  always_comb begin
    if (acc > BACK_CLAMP) begin
      acc_cl = BACK_CLAMP;
    end else if (acc < -BACK_CLAMP) begin
      acc_cl = -BACK_CLAMP;
    end else begin
      acc_cl = acc;
    end

    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    case (state)
      ST_PROP: begin
        mac_ctl.mul_en = 1'b1;
        op_a = {{(OPA_W-7){err[6]}}, err};
        op_b = {1'b0, prop_gain};
      end
      ST_INTEG: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_load = 1'b1;
        op_a = {{(OPA_W-15){err_sum[14]}}, err_sum};
        op_b = {1'b0, integ_gain};
      end
      ST_DERIV: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.acc_add = 1'b1;
        op_a = {{(OPA_W-8){diff[7]}}, diff};
        op_b = {1'b0, deriv_gain};
      end
      ST_SUM: begin
        mac_ctl.acc_add = 1'b1;
      end
      ST_BACK: begin
        mac_ctl.mul_en = 1'b1;
        op_a = acc_cl[OPA_W-1:0];
        op_b = BACK_SCALE;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  // ---------------- mixing: truncate toward zero, then saturate
  function automatic logic signed [13:0] sat_drive(input logic signed [PROD_W-1:0] v,
                                                   input logic [12:0] lim);
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] ns;
    logic signed [13:0]       r;
    s  = {{(PROD_W-13){1'b0}}, lim};
    ns = -s;
    if (v > s) begin
      r = s[13:0];
    end else if (v < ns) begin
      r = ns[13:0];
    end else begin
      r = v[13:0];
    end
    return r;
  endfunction

  logic signed [PROD_W-1:0] acc_x, base_x, lx, rx, lq, rq, bq8, bq18;
  logic signed [PROD_W-1:0] lx_adj, rx_adj, ax_adj, px_adj;
  logic                     mix_go;

  always_comb begin
    acc_x  = {{(PROD_W-ACC_W){acc[ACC_W-1]}}, acc};
    base_x = {{(PROD_W-20){base_speed[11]}}, base_speed, 8'b0};
    lx     = acc_x + base_x;
    rx     = acc_x - base_x;
    lx_adj = lx + (lx[PROD_W-1] ? PROD_W'(255) : '0);
    rx_adj = rx + (rx[PROD_W-1] ? PROD_W'(255) : '0);
    ax_adj = acc_x + (acc_x[PROD_W-1] ? PROD_W'(255) : '0);
    px_adj = prod + (prod[PROD_W-1] ? PROD_W'(262143) : '0);
    lq     = lx_adj >>> 8;
    rq     = rx_adj >>> 8;
    bq8    = ax_adj >>> 8;
    bq18   = px_adj >>> 18;
  end

  assign mix_go = (state == ST_MIX) && (!out_valid || drv.ready);

  // ---------------- sequencer, state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      prop_gain     <= PROP_GAIN_RST;
      integ_gain    <= '0;
      deriv_gain    <= '0;
      line_polarity <= 1'b0;
      integ_limit   <= INTEG_LIM_RST;
      pwm_limit     <= PWM_LIM_RST;
      err_sum       <= '0;
      last_err      <= '0;
      base_speed    <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_PROP_GAIN:  prop_gain     <= cfg.data;
          REG_INTEG_GAIN: integ_gain    <= cfg.data;
          REG_DERIV_GAIN: deriv_gain    <= cfg.data;
          REG_POLARITY:   line_polarity <= cfg.data[0];
          REG_INTEG_LIM:  integ_limit   <= cfg.data[13:0];
          REG_PWM_LIM:    pwm_limit     <= cfg.data[12:0];
          default: ;
        endcase
      end

      if (drv.ready && !mix_go) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            err        <= e_new;
            diff       <= diff_next;
            run_q      <= sens.run_enable;
            wz_q       <= wz;
            err_sum    <= sum_next;
            last_err   <= e_new;
            base_speed <= base_next;
            state      <= ST_PROP;
          end
        end
        ST_PROP:  state <= ST_INTEG;
        ST_INTEG: state <= ST_DERIV;
        ST_DERIV: state <= ST_SUM;
        ST_SUM:   state <= ST_BACK;
        ST_BACK:  state <= ST_MIX;
        ST_MIX: begin
          if (mix_go) begin
            out_valid <= 1'b1;
            lerr_q    <= err;
            if (run_q) begin
              left_q  <= sat_drive(lq, pwm_limit);
              right_q <= sat_drive(rq, pwm_limit);
              back_q  <= sat_drive(wz_q ? bq18 : bq8, pwm_limit);
            end else begin
              left_q  <= '0;
              right_q <= '0;
              back_q  <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign sens.ready      = (state == ST_IDLE);
  assign cfg.ready       = 1'b1;
  assign drv.valid       = out_valid;
  assign drv.drive_left  = left_q;
  assign drv.drive_right = right_q;
  assign drv.drive_back  = back_q;
  assign drv.line_error  = lerr_q;

  `ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == ST_PROP, "sequencer did not start on accept")
  `ASSERT_NEXT(a_mix_loads, clk, rst, mix_go, drv.valid && state == ST_IDLE, "result beat not loaded")
  `ASSERT_NEXT(a_stopped_zero, clk, rst, mix_go && !run_q, drv.drive_left == '0 && drv.drive_right == '0 && drv.drive_back == '0, "drives not zero while stopped")
  `ASSERT_IMPLY(a_err_range, clk, rst, drv.valid, drv.line_error <= 7'sd32 && drv.line_error >= -7'sd32, "line error out of range")

endmodule

@@ sv/lfpm_mac.sv @@
module lfpm_mac import lfpm_pkg::*; (
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [OPA_W-1:0]  op_a,
  input  logic signed [OPB_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod,
  output logic signed [ACC_W-1:0]  acc
);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= op_a * op_b;
    end
    if (ctl.acc_load) begin
      acc <= prod[ACC_W-1:0];
    end else if (ctl.acc_add) begin
      acc <= acc + prod[ACC_W-1:0];
    end
  end

endmodule
